### rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and types of the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int CELL_AW = $clog2(CELLS);
    localparam int PHYS_W  = $clog2(ROWS);
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;

    localparam logic [7:0] DEFAULT_COLOR = 8'h1f;
    localparam logic [7:0] NEWLINE_BYTE  = 8'h0a;
    localparam logic [7:0] SPACE_BYTE    = 8'h20;

    typedef enum logic [1:0] {
        ACT_PUT   = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_WRITE,
        CMD_READ,
        CMD_SWEEP
    } cmd_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SWEEP,
        BK_DONE
    } back_state_t;

    typedef struct packed {
        logic [7:0]       cell_char;
        logic [7:0]       cell_color;
        logic [COL_W-1:0] cursor_col;
        logic [ROW_W-1:0] cursor_row;
        logic             scrolled;
    } res_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [CELL_AW-1:0] row_base;
        logic [COL_W-1:0]   col;
        logic [7:0]         wr_char;
        res_t               res;
    } cmd_t;

    typedef struct packed {
        logic push;
        cmd_t cmd;
    } q_wr_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_rd_t;

endpackage

`default_nettype wire

### rtl/text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Teletype-style 80x25 character console with a scrolling ring of rows.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: tuser carries the action (put, read, clear), tdata the
//   character and the read coordinates. Every accepted word yields exactly one
//   result word on m_axis with the cell read (if any), cursor and scroll flag.
//   cfg_we/cfg_wdata load the attribute byte; write it only while idle.
// Command handling:
//   Put of an ordinary character into a row already written, newline, clear,
//   read of a blank row or an unused action: the result is loaded as the
//   command pops, one word per cycle while m_axis is not stalled. Read of a
//   written cell (store read port is registered) and first put into a row
//   after clear, reset or scroll, which blanks that row in one pass of 80 store
//   writes merging the character: back end busy until the result is loaded.
// Reset:
//   Clears cursor, ring offset and all row valid bits at once; rows never
//   written read as spaces, so no clearing pass over the store is needed.
// Stall:
//   A stalled m_axis holds the result word; the front keeps accepting until the
//   two-entry command queue is full (a read or a row blanking may also wait in
//   the back end), then s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration: attribute byte
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // char_in[7:0], read_row[12:8], read_col[19:13]
    input  wire logic [1:0]  s_axis_tuser,   // action[1:0]
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // cell_char[7:0], cell_color[15:8],
                                             // cursor_col[22:16], cursor_row[27:23],
                                             // scrolled[28]
);
    import tcw_pkg::*;

    q_wr_t q_wr;
    q_rd_t q_rd;
    logic  q_full;
    logic  q_pop;
    res_t  m_res;

    // Front: classify the action and advance the cursor on accept.
    tcw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .action    (s_axis_tuser),
        .char_in   (s_axis_tdata[7:0]),
        .read_row  (s_axis_tdata[12:8]),
        .read_col  (s_axis_tdata[19:13]),
        .q_full    (q_full),
        .q_wr      (q_wr)
    );

    // Queue: decouple front acceptance from store work.
    tcw_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_wr   (q_wr),
        .q_full (q_full),
        .q_rd   (q_rd),
        .q_pop  (q_pop)
    );

    // Back: write, blank or read the store, then present the result word.
    tcw_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_rd    (q_rd),
        .q_pop   (q_pop),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_res   (m_res)
    );

    // Pack result fields from the lowest bit up; pad to a whole byte.
    assign m_axis_tdata = {3'b000, m_res.scrolled, m_res.cursor_row, m_res.cursor_col,
                           m_res.cell_color, m_res.cell_char};

endmodule

`default_nettype wire

### rtl/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front
// Accept actions, keep cursor, ring offset and row valid bits, issue commands.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [7:0]                 cfg_wdata,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [1:0]                 action,
    input  wire logic [7:0]                 char_in,
    input  wire logic [tcw_pkg::ROW_W-1:0]  read_row,
    input  wire logic [tcw_pkg::COL_W-1:0]  read_col,
    input  wire logic                       q_full,
    output tcw_pkg::q_wr_t                  q_wr
);
    import tcw_pkg::*;

    logic [COL_W-1:0]  cur_col_reg,   cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg,   cur_row_next;
    logic [PHYS_W-1:0] top_reg,       top_next;
    logic [ROWS-1:0]   row_valid_reg, row_valid_next;
    logic [7:0]        color_reg;

    logic              accept;
    logic              scroll;
    logic [PHYS_W-1:0] top_adv;
    logic [PHYS_W-1:0] put_top;
    logic [ROW_W-1:0]  put_row;
    logic [COL_W-1:0]  put_col;
    logic [COL_W-1:0]  col_inc;
    logic [PHYS_W:0]   put_sum;
    logic [PHYS_W-1:0] put_phys;
    logic [PHYS_W:0]   rd_sum;
    logic [PHYS_W-1:0] rd_phys;
    logic              rd_in_range;
    logic [ROWS-1:0]   valid_scr;
    cmd_t              cmd;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Ring position arithmetic: sums stay below twice the row count for in-range rows.
    always_comb
    begin
        scroll  = (cur_row_reg >= ROW_W'(ROWS));
        top_adv = (top_reg == PHYS_W'(ROWS - 1)) ? '0 : top_reg + 1'b1;
        put_top = scroll ? top_adv : top_reg;
        put_row = scroll ? ROW_W'(ROWS - 1) : cur_row_reg;
        put_col = scroll ? '0 : cur_col_reg;
        col_inc = put_col + 1'b1;
        put_sum = (PHYS_W + 1)'(put_row) + {1'b0, put_top};
        put_phys = (put_sum >= (PHYS_W + 1)'(ROWS)) ?
                   PHYS_W'(put_sum - (PHYS_W + 1)'(ROWS)) : PHYS_W'(put_sum);
        rd_in_range = (read_row < ROW_W'(ROWS)) && (read_col < COL_W'(COLUMNS));
        rd_sum  = (PHYS_W + 1)'(read_row) + {1'b0, top_reg};
        rd_phys = (rd_sum >= (PHYS_W + 1)'(ROWS)) ?
                  PHYS_W'(rd_sum - (PHYS_W + 1)'(ROWS)) : PHYS_W'(rd_sum);
        valid_scr = row_valid_reg;
        if (scroll)
        begin
            // New bottom row is the old top row: drop its contents.
            valid_scr[top_reg] = 1'b0;
        end
    end

    always_comb
    begin
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        top_next       = top_reg;
        row_valid_next = row_valid_reg;
        cmd.kind       = CMD_NONE;
        cmd.row_base   = '0;
        cmd.col        = '0;
        cmd.wr_char    = char_in;
        cmd.res.cell_char  = '0;
        cmd.res.cell_color = '0;
        cmd.res.scrolled   = 1'b0;

        unique case (action_t'(action))
            ACT_PUT:
            begin
                top_next         = put_top;
                row_valid_next   = valid_scr;
                cmd.res.scrolled = scroll;
                cmd.row_base     = CELL_AW'(put_phys) * CELL_AW'(COLUMNS);
                cmd.col          = put_col;
                if (char_in == NEWLINE_BYTE)
                begin
                    cur_row_next = put_row + 1'b1;
                    cur_col_next = '0;
                end
                else
                begin
                    // A row not yet valid is blanked in the same pass as the write.
                    cmd.kind = valid_scr[put_phys] ? CMD_WRITE : CMD_SWEEP;
                    row_valid_next[put_phys] = 1'b1;
                    if (col_inc >= COL_W'(COLUMNS))
                    begin
                        cur_row_next = put_row + 1'b1;
                        cur_col_next = '0;
                    end
                    else
                    begin
                        cur_row_next = put_row;
                        cur_col_next = col_inc;
                    end
                end
            end
            ACT_READ:
            begin
                if (rd_in_range)
                begin
                    cmd.res.cell_color = color_reg;
                    cmd.row_base = CELL_AW'(rd_phys) * CELL_AW'(COLUMNS);
                    cmd.col      = read_col;
                    if (row_valid_reg[rd_phys])
                    begin
                        cmd.kind = CMD_READ;
                    end
                    else
                    begin
                        cmd.res.cell_char = SPACE_BYTE;
                    end
                end
            end
            ACT_CLEAR:
            begin
                cur_col_next   = '0;
                cur_row_next   = '0;
                top_next       = '0;
                row_valid_next = '0;
            end
            ACT_NONE:
            begin
            end
            default:
            begin
            end
        endcase

        cmd.res.cursor_col = cur_col_next;
        cmd.res.cursor_row = cur_row_next;
    end

    assign q_wr.push = accept;
    assign q_wr.cmd  = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            top_reg       <= '0;
            row_valid_reg <= '0;
            color_reg     <= DEFAULT_COLOR;
        end
        else
        begin
            if (accept)
            begin
                cur_col_reg   <= cur_col_next;
                cur_row_reg   <= cur_row_next;
                top_reg       <= top_next;
                row_valid_reg <= row_valid_next;
            end
            if (cfg_we)
            begin
                color_reg <= cfg_wdata;
            end
        end
    end

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_col_reg < COL_W'(COLUMNS))
        else $error("cursor column out of range");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_row_reg <= ROW_W'(ROWS))
        else $error("cursor row out of range");

    a_clear_home: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && action == ACT_CLEAR) |=> (row_valid_reg == '0 && top_reg == '0))
        else $error("clear did not reset the ring");

endmodule

`default_nettype wire

### rtl/tcw_queue.sv
// ----------------------------------------------------------------------------
// tcw_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire tcw_pkg::q_wr_t  q_wr,
    output logic                 q_full,
    output tcw_pkg::q_rd_t       q_rd,
    input  wire logic            q_pop
);
    import tcw_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       do_push;
    logic       do_pop;

    assign q_full    = (count_reg == 2'd2);
    assign q_rd.valid = (count_reg != 2'd0);
    assign q_rd.cmd   = entry_reg[rd_ptr_reg];
    assign do_push   = q_wr.push && !q_full;
    assign do_pop    = q_pop && q_rd.valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= q_wr.cmd;
        end
    end

endmodule

`default_nettype wire

### rtl/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back
// Execute commands on the character store and hold the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire tcw_pkg::q_rd_t  q_rd,
    output logic                 q_pop,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output tcw_pkg::res_t        m_res
);
    import tcw_pkg::*;

    logic [7:0]         mem [CELLS];
    logic [7:0]         rd_data_reg;

    back_state_t        state_reg, state_next;
    cmd_t               cmd_reg;
    logic [COL_W-1:0]   sweep_cnt_reg, sweep_cnt_next;
    logic               out_valid_reg, out_valid_next;
    res_t               out_res_reg;

    logic               out_free;
    logic               out_load;
    res_t               out_res;
    logic               cmd_load;
    logic               mem_we;
    logic               mem_re;
    logic [CELL_AW-1:0] mem_addr;
    logic [7:0]         mem_wdata;
    logic               sweep_last;

    assign out_free   = !out_valid_reg || m_ready;
    assign sweep_last = (sweep_cnt_reg == COL_W'(COLUMNS - 1));

    // Next state
    always_comb
    begin
        state_next     = state_reg;
        sweep_cnt_next = sweep_cnt_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                sweep_cnt_next = '0;
                if (q_rd.valid)
                begin
                    if (q_rd.cmd.kind == CMD_READ)
                    begin
                        state_next = BK_DONE;
                    end
                    else if (q_rd.cmd.kind == CMD_SWEEP)
                    begin
                        state_next = BK_SWEEP;
                    end
                end
            end
            BK_SWEEP:
            begin
                sweep_cnt_next = sweep_cnt_reg + 1'b1;
                if (sweep_last)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        q_pop     = 1'b0;
        cmd_load  = 1'b0;
        out_load  = 1'b0;
        out_res   = q_rd.cmd.res;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = q_rd.cmd.row_base + CELL_AW'(q_rd.cmd.col);
        mem_wdata = q_rd.cmd.wr_char;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_rd.valid)
                begin
                    case (q_rd.cmd.kind)
                        CMD_NONE:
                        begin
                            q_pop    = out_free;
                            out_load = out_free;
                        end
                        CMD_WRITE:
                        begin
                            q_pop    = out_free;
                            out_load = out_free;
                            mem_we   = out_free;
                        end
                        CMD_READ:
                        begin
                            q_pop    = 1'b1;
                            cmd_load = 1'b1;
                            mem_re   = 1'b1;
                        end
                        default:
                        begin
                            q_pop    = 1'b1;
                            cmd_load = 1'b1;
                        end
                    endcase
                end
            end
            BK_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_addr  = cmd_reg.row_base + CELL_AW'(sweep_cnt_reg);
                mem_wdata = (sweep_cnt_reg == cmd_reg.col) ? cmd_reg.wr_char : SPACE_BYTE;
            end
            BK_DONE:
            begin
                out_load = out_free;
                out_res  = cmd_reg.res;
                if (cmd_reg.kind == CMD_READ)
                begin
                    out_res.cell_char = rd_data_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            sweep_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_load)
        begin
            cmd_reg <= q_rd.cmd;
        end
        if (out_load)
        begin
            out_res_reg <= out_res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    assign m_valid = out_valid_reg;
    assign m_res   = out_res_reg;

    a_sweep_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_SWEEP) |-> (sweep_cnt_reg < COL_W'(COLUMNS)))
        else $error("sweep counter past last column");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == BK_IDLE && q_rd.valid))
        else $error("command popped outside idle");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || m_ready))
        else $error("result word overwritten before taken");

endmodule

`default_nettype wire
